// ===== sv/vpl_pkg.sv =====
// ----------------------------------------------------------------------------
// vpl_pkg: shared types and constants for the vertex line projector
// Holds the controller state type, the command and status bundles and the
// fixed constants of the projection arithmetic.
// ----------------------------------------------------------------------------
package vpl_pkg;

    localparam int ROW_BITS     = 64;   // one matrix row register
    localparam int NUM_ROWS     = 4;
    localparam int ACC_BITS     = 40;   // kept width of every product sum
    localparam int HALF_BITS    = ACC_BITS / 2;
    localparam int POS_BITS     = 16;
    localparam int PIX_BITS     = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int STEP_W       = 6;    // 2 stages x 4 rows x 4 columns x 2 halves
    localparam int X_OFFSET     = 64;
    localparam int Y_OFFSET     = 32;
    localparam int PIXEL_LIMIT  = 256;
    localparam logic [ROW_BITS-1:0] IDENT_ONE = 64'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROW0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_ROW0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 4'd8;

    localparam logic COORD_X = 1'b0;
    localparam logic COORD_Y = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_POST,
        ST_PAIR
    } vpl_state_t;

    typedef struct packed {
        logic                load;
        logic                mac_en;
        logic [STEP_W-1:0]   step;
        logic                div_init;
        logic                div_step;
        logic                div_post;
        logic                coord;
        logic                hold_en;
        logic                emit_en;
    } vpl_cmd_t;

    typedef struct packed {
        logic w_zero;
        logic frame_start;
    } vpl_status_t;

endpackage

// ===== sv/vpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpl_ctrl: sequencing state machine of the vertex line projector
// Steps the shared multiply-accumulate, runs the divider per coordinate and
// tracks segment pairing and the output register.
// ----------------------------------------------------------------------------
module vpl_ctrl import vpl_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        m_tready,
    output logic        m_tvalid,
    input  vpl_status_t status,
    output vpl_cmd_t    cmd
);

    localparam int DW = ACC_BITS + FRACTION_BITS;
    localparam int BW = $clog2(DW);
    localparam logic [STEP_W-1:0] STEP_LAST = '1;

    vpl_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BW-1:0]     bit_reg, bit_next;
    logic              coord_reg, coord_next;
    logic              phase_reg, phase_next;
    logic              mvalid_reg, mvalid_next;
    logic              out_free;
    logic              pair_open;

    assign out_free  = !mvalid_reg || m_tready;
    // a frame start drops any held segment start
    assign pair_open = phase_reg && !status.frame_start;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_MAC;
            ST_MAC:      if (step_reg == STEP_LAST) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = status.w_zero ? ST_PAIR : ST_DIV_RUN;
            ST_DIV_RUN:  if (bit_reg == '0) state_next = ST_DIV_POST;
            ST_DIV_POST: state_next = (coord_reg == COORD_Y) ? ST_PAIR : ST_DIV_INIT;
            ST_PAIR:     if (!pair_open || out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.coord    = coord_reg;
        s_tready     = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mac_en   = (state_reg == ST_MAC);
        cmd.div_init = (state_reg == ST_DIV_INIT) && !status.w_zero;
        cmd.div_step = (state_reg == ST_DIV_RUN);
        cmd.div_post = (state_reg == ST_DIV_POST);
        cmd.hold_en  = (state_reg == ST_PAIR) && !pair_open;
        cmd.emit_en  = (state_reg == ST_PAIR) && pair_open && out_free;
    end

    always_comb begin
        step_next   = (state_reg == ST_MAC) ? step_reg + 1'b1 : '0;
        bit_next    = bit_reg;
        if (state_reg == ST_DIV_INIT) begin
            bit_next = BW'(DW - 1);
        end else if (state_reg == ST_DIV_RUN) begin
            bit_next = bit_reg - 1'b1;
        end
        coord_next  = coord_reg;
        if (state_reg == ST_IDLE) begin
            coord_next = COORD_X;
        end else if (state_reg == ST_DIV_POST) begin
            coord_next = COORD_Y;
        end
        phase_next  = phase_reg;
        if (cmd.hold_en) begin
            phase_next = 1'b1;
        end else if (cmd.emit_en) begin
            phase_next = 1'b0;
        end
        mvalid_next = cmd.emit_en ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            bit_reg    <= '0;
            coord_reg  <= COORD_X;
            phase_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            coord_reg  <= coord_next;
            phase_reg  <= phase_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

// ===== sv/vpl_datapath.sv =====
// ----------------------------------------------------------------------------
// vpl_datapath: matrix registers, shared multiply-accumulate and divider
// Forms view then projection products one partial product a cycle, divides
// x and y by w one quotient bit a cycle and maps them to screen pixels.
// ----------------------------------------------------------------------------
module vpl_datapath import vpl_pkg::*; #(
    parameter int COEFF_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ROW_BITS-1:0]        cfg_data,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    input  logic signed [POS_BITS-1:0] pos_z,
    input  logic                       frame_start,
    input  vpl_cmd_t                   cmd,
    output vpl_status_t                status,
    output logic [PIX_BITS-1:0]        start_x,
    output logic [PIX_BITS-1:0]        start_y,
    output logic [PIX_BITS-1:0]        end_x,
    output logic [PIX_BITS-1:0]        end_y,
    output logic                       clipped,
    output logic                       w_zero
);

    localparam int AW  = ACC_BITS + FRACTION_BITS;
    localparam int DW  = AW;
    localparam int MW  = HALF_BITS + 1;
    localparam int PW  = COEFF_BITS + MW;
    localparam int QW  = DW + 2;
    localparam logic signed [QW-1:0] LOW_LIM  = -(QW'(1) << FRACTION_BITS);
    localparam logic signed [QW-1:0] HIGH_LIM = QW'(PIXEL_LIMIT) << FRACTION_BITS;
    localparam logic signed [QW-1:0] X_OFF    = QW'(X_OFFSET) << FRACTION_BITS;
    localparam logic signed [QW-1:0] Y_OFF    = QW'(Y_OFFSET) << FRACTION_BITS;

    function automatic logic signed [COEFF_BITS-1:0] lane(
        input logic [ROW_BITS-1:0] row,
        input logic [1:0]          j
    );
        logic [ROW_BITS+4*COEFF_BITS-1:0] wide;
        int unsigned                      sh;
        wide = {{(4*COEFF_BITS){1'b0}}, row};
        sh   = 32'(j) * COEFF_BITS;
        if (sh >= ROW_BITS) return '0;
        return wide[sh +: COEFF_BITS];
    endfunction

    logic [ROW_BITS-1:0]        view_reg [NUM_ROWS];
    logic [ROW_BITS-1:0]        proj_reg [NUM_ROWS];
    logic signed [ACC_BITS-1:0] v_reg [NUM_ROWS];
    logic signed [ACC_BITS-1:0] t_reg [NUM_ROWS];
    logic signed [ACC_BITS-1:0] c_reg [NUM_ROWS];
    logic [AW-1:0]              acc_reg;
    logic                       fs_reg;

    logic                       stage, half;
    logic [1:0]                 row_sel, col_sel;
    logic [ROW_BITS-1:0]        row_bits;
    logic signed [COEFF_BITS-1:0] coef;
    logic signed [ACC_BITS-1:0] opnd;
    logic signed [MW-1:0]       mul_b;
    logic signed [PW-1:0]       prod;
    logic [AW-1:0]              prod_ext;
    logic [AW-1:0]              acc_next;

    assign stage   = cmd.step[5];
    assign row_sel = cmd.step[4:3];
    assign col_sel = cmd.step[2:1];
    assign half    = cmd.step[0];

    always_comb begin
        row_bits = stage ? proj_reg[row_sel] : view_reg[row_sel];
        coef     = lane(row_bits, col_sel);
        opnd     = stage ? t_reg[col_sel] : v_reg[col_sel];
        // low half unsigned, high half signed
        mul_b    = half ? MW'(opnd[ACC_BITS-1:HALF_BITS])
                        : $signed({1'b0, opnd[HALF_BITS-1:0]});
        if (half) mul_b = $signed({opnd[ACC_BITS-1], opnd[ACC_BITS-1:HALF_BITS]});
        prod     = coef * mul_b;
        prod_ext = AW'(prod);
        if (half) prod_ext = prod_ext << HALF_BITS;
        acc_next = ((col_sel == 2'd0 && !half) ? '0 : acc_reg) + prod_ext;
    end

    // divider
    logic [DW-1:0]         dvd_reg;
    logic [ACC_BITS-1:0]   rem_reg;
    logic [ACC_BITS-1:0]   dvs_reg;
    logic                  neg_reg;
    logic signed [ACC_BITS-1:0] num_sel, den;
    logic [ACC_BITS:0]     trial;
    logic                  qbit;
    logic signed [QW-1:0]  qsig, pos;
    logic [PIX_BITS-1:0]   pix;
    logic                  clip_now;

    logic [PIX_BITS-1:0]   px_reg, py_reg, held_x_reg, held_y_reg;
    logic                  clip_reg, held_clip_reg, held_wz_reg;

    always_comb begin
        num_sel = (cmd.coord == COORD_Y) ? c_reg[1] : c_reg[0];
        den     = c_reg[3];
        trial   = {rem_reg, dvd_reg[DW-1]};
        qbit    = (trial >= {1'b0, dvs_reg});
        qsig    = neg_reg ? -$signed({2'b0, dvd_reg}) : $signed({2'b0, dvd_reg});
        pos     = qsig + ((cmd.coord == COORD_Y) ? Y_OFF : X_OFF);
        clip_now = 1'b0;
        if (pos <= LOW_LIM) begin
            pix      = '0;
            clip_now = 1'b1;
        end else if (pos >= HIGH_LIM) begin
            pix      = '1;
            clip_now = 1'b1;
        end else if (pos < 0) begin
            pix = '0;
        end else begin
            pix = pos[FRACTION_BITS +: PIX_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                view_reg[i] <= IDENT_ONE << (16 * i);
                proj_reg[i] <= IDENT_ONE << (16 * i);
            end
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_clip_reg <= 1'b0;
            held_wz_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index < CFG_PROJ_ROW0) begin
                    view_reg[cfg_index[1:0]] <= cfg_data;
                end else if (cfg_index < CFG_END) begin
                    proj_reg[cfg_index[1:0]] <= cfg_data;
                end
            end
            if (cmd.hold_en) begin
                held_x_reg    <= px_reg;
                held_y_reg    <= py_reg;
                held_clip_reg <= clip_reg;
                held_wz_reg   <= status.w_zero;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg[0] <= ACC_BITS'(pos_x);
            v_reg[1] <= ACC_BITS'(pos_y);
            v_reg[2] <= ACC_BITS'(pos_z);
            v_reg[3] <= ACC_BITS'(1) << FRACTION_BITS;
            fs_reg   <= frame_start;
            px_reg   <= '0;
            py_reg   <= '0;
            clip_reg <= 1'b0;
        end
        if (cmd.mac_en) begin
            acc_reg <= acc_next;
            if (col_sel == 2'd3 && half) begin
                if (stage) c_reg[row_sel] <= acc_next[FRACTION_BITS +: ACC_BITS];
                else       t_reg[row_sel] <= acc_next[FRACTION_BITS +: ACC_BITS];
            end
        end
        if (cmd.div_init) begin
            neg_reg <= num_sel[ACC_BITS-1] ^ den[ACC_BITS-1];
            dvd_reg <= {(num_sel[ACC_BITS-1] ? -num_sel : num_sel),
                        {FRACTION_BITS{1'b0}}};
            dvs_reg <= den[ACC_BITS-1] ? -den : den;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= qbit ? ACC_BITS'(trial - {1'b0, dvs_reg}) : trial[ACC_BITS-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], qbit};
        end
        if (cmd.div_post) begin
            if (cmd.coord == COORD_Y) py_reg <= pix;
            else                      px_reg <= pix;
            clip_reg <= clip_reg | clip_now;
        end
        if (cmd.emit_en) begin
            start_x <= held_x_reg;
            start_y <= held_y_reg;
            end_x   <= px_reg;
            end_y   <= py_reg;
            clipped <= held_clip_reg | clip_reg;
            w_zero  <= held_wz_reg | status.w_zero;
        end
    end

    assign status.w_zero      = (c_reg[3] == '0);
    assign status.frame_start = fs_reg;

endmodule

// ===== sv/vertex_project_line_pairs_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_project_line_pairs_unit: projects vertices and pairs them into lines
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one vertex per transaction; s_tdata carries x, y, z in signed
//   Q8.8, s_tuser flags a frame start (the vertex opens a new segment).
//   m_ channel: one line segment per transaction on every second vertex.
//   cfg channel: writes a view row (index 0..3) or projection row (4..7);
//   other indexes are ignored. Write only while the block is idle.
// Occupancy:
//   one vertex occupies the block through the multiply-accumulate steps, a
//   divide over DW = 40 + FRACTION_BITS quotient bits for each of x and y
//   and the pairing step; a vertex with zero w skips the divider. The single
//   shared multiplier (two partial products per matrix term, 32 terms) and
//   one-bit-per-cycle divider set this; s_tready is high only idle.
// Reset: matrices return to identity, pairing expects a segment start and
//   the output register empties.
// Stall: a finished segment waits in the output register; the next vertex is
//   still taken and computed, and the block holds only when it has a second
//   segment to deliver before the first is taken.
// ----------------------------------------------------------------------------
module vertex_project_line_pairs_unit import vpl_pkg::*; #(
    parameter int COEFF_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // pos_x, pos_y, pos_z
    input  logic                 s_tuser,   // frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // start_x, start_y, end_x, end_y
    output logic [1:0]           m_tuser,   // clipped, w_zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_BITS-1:0]  cfg_data
);

    vpl_cmd_t    cmd;
    vpl_status_t status;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    vpl_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    vpl_datapath #(
        .COEFF_BITS   (COEFF_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pos_x       (s_tdata[15:0]),
        .pos_y       (s_tdata[31:16]),
        .pos_z       (s_tdata[47:32]),
        .frame_start (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .start_x     (m_tdata[7:0]),
        .start_y     (m_tdata[15:8]),
        .end_x       (m_tdata[23:16]),
        .end_y       (m_tdata[31:24]),
        .clipped     (m_tuser[0]),
        .w_zero      (m_tuser[1])
    );

endmodule

// ===== sv/vpl_checker.sv =====
// ----------------------------------------------------------------------------
// vpl_checker: port-level checks for the vertex line projector
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module vpl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // leave reset idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // one vertex at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("vertex taken while busy");

    // a new result needs a vertex to have entered
    a_result_needs_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

endmodule

bind vertex_project_line_pairs_unit vpl_checker u_vpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
